// ----- sv/ictf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the complementary tilt filter
// no dependencies

package ictf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_HIGH     = 3'd5;

    localparam logic [31:0] GYRO_GAIN_RST    = 32'd327680;
    localparam logic [31:0] ACCEL_GAIN_RST   = 32'd65536;
    localparam logic [15:0] GYRO_WEIGHT_RST  = 16'd32112;
    localparam logic [15:0] ACCEL_WEIGHT_RST = 16'd655;
    localparam logic [16:0] MAG_LOW_RST      = 17'd0;
    localparam logic [16:0] MAG_HIGH_RST     = 17'd98304;

    // pi in q2.30
    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

    // round(atan(2^-i) * 2^30)
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] tilt_x;
        logic signed [31:0] tilt_y;
        logic               accel_applied;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GMUL,
        OP_GADD,
        OP_CINIT,
        OP_CSTEP,
        OP_AMUL,
        OP_ASAT,
        OP_BMUL_G,
        OP_BMUL_A,
        OP_BFIN,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic axis;     // 0: x angle, 1: y angle
    } cmd_t;

    typedef struct packed {
        logic use_acc;
        logic iter_last;
        logic out_free;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if ((&v[65:31]) || !(|v[65:31]))
            return v[31:0];
        else if (v[65])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

endpackage

// ----- sv/imu_complementary_tilt_filter.sv -----
`timescale 1ns / 1ps
// Complementary tilt filter: each request integrates the gyro x/y rates into two
// q16.16 tilt angles and, when |ax|+|ay|+|az| lies in [mag_low, mag_high], blends
// in cordic atan2 angles from the accelerometer. One request is worked at a time
// through a single shared 33x33 multiplier and one cordic unit run once per axis:
// gyro multiply and add per axis, then, when the accelerometer is blended in,
// cordic init, steps, multiply and saturate per axis and a blend per axis. The
// finished result sits in an output register, so the next request is taken while
// it waits. Configuration writes take effect at once and belong to idle periods.
// depends on ictf_pkg, ictf_ctrl, ictf_dp

module imu_complementary_tilt_filter
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data
);

    cmd_t    cmd;
    status_t status;

    ictf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ictf_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sv/ictf_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer of the tilt filter: walks one request through gyro, cordic and blend
// depends on ictf_pkg

module ictf_ctrl
    import ictf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_GMUL   = 11'b000_0000_0010,
        S_GADD   = 11'b000_0000_0100,
        S_CINIT  = 11'b000_0000_1000,
        S_CSTEP  = 11'b000_0001_0000,
        S_AMUL   = 11'b000_0010_0000,
        S_ASAT   = 11'b000_0100_0000,
        S_BMUL_G = 11'b000_1000_0000,
        S_BMUL_A = 11'b001_0000_0000,
        S_BFIN   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 1'b0;
                    state_next = S_GMUL;
                end
            end
            S_GMUL:
            begin
                cmd.op     = OP_GMUL;
                state_next = S_GADD;
            end
            S_GADD:
            begin
                cmd.op = OP_GADD;
                if (axis_reg)
                begin
                    axis_next  = 1'b0;
                    state_next = status.use_acc ? S_CINIT : S_DONE;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_GMUL;
                end
            end
            S_CINIT:
            begin
                cmd.op     = OP_CINIT;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op = OP_CSTEP;
                if (status.iter_last)
                    state_next = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.op     = OP_AMUL;
                state_next = S_ASAT;
            end
            S_ASAT:
            begin
                cmd.op     = OP_ASAT;
                axis_next  = !axis_reg;
                state_next = axis_reg ? S_BMUL_G : S_CINIT;
            end
            S_BMUL_G:
            begin
                cmd.op     = OP_BMUL_G;
                state_next = S_BMUL_A;
            end
            S_BMUL_A:
            begin
                cmd.op     = OP_BMUL_A;
                state_next = S_BFIN;
            end
            S_BFIN:
            begin
                cmd.op     = OP_BFIN;
                axis_next  = !axis_reg;
                state_next = axis_reg ? S_DONE : S_BMUL_G;
            end
            S_DONE:
            begin
                // wait for the output slot to free up
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while the previous one is in flight");

    a_out_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> status.out_free)
        else $error("result loaded over an unread result");

    a_cordic_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CSTEP && !status.iter_last |=> state_reg == S_CSTEP)
        else $error("cordic left before its last step");

endmodule

// ----- sv/ictf_dp.sv -----
`timescale 1ns / 1ps
// datapath of the tilt filter: config registers, angle state, shared multiplier,
// cordic unit and output register; depends on ictf_pkg

module ictf_dp
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_t                   in_data,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic [31:0] gyro_gain_reg, accel_gain_reg;
    logic [15:0] gyro_weight_reg, accel_weight_reg;
    logic [16:0] mag_low_reg, mag_high_reg;

    in_t                in_reg;
    logic               use_reg;
    logic signed [31:0] angle_x_reg, angle_y_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               zero_reg;
    logic [IW-1:0]      iter_reg;
    logic signed [65:0] prod_reg, sum_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic [16:0]        mag;
    logic               use_next;
    logic signed [15:0] side, down;
    logic signed [33:0] x0, y0, xs, ys;
    logic signed [34:0] atan_step, z_sh;
    logic signed [17:0] a_cl;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] gyro_sum, blend_sum;
    logic signed [31:0] angle_sel, acc_sel;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : e;
    endfunction

    assign mag = abs16(in_data.accel_x) + abs16(in_data.accel_y) + abs16(in_data.accel_z);
    assign use_next = (mag >= mag_low_reg) && (mag <= mag_high_reg);

    assign side = cmd.axis ? in_reg.accel_y : in_reg.accel_x;
    assign down = in_reg.accel_z;
    assign x0   = {{4{down[15]}}, down, 14'b0};
    assign y0   = {{4{side[15]}}, side, 14'b0};

    assign xs        = cx_reg >>> iter_reg;
    assign ys        = cy_reg >>> iter_reg;
    assign atan_step = {5'b0, ATAN_TAB[iter_reg]};

    // q2.30 to q16.16, clamped to one radian
    assign z_sh = cz_reg >>> 14;
    always_comb
    begin
        if (z_sh > 35'sd65536)
            a_cl = 18'sd65536;
        else if (z_sh < -35'sd65536)
            a_cl = -18'sd65536;
        else
            a_cl = z_sh[17:0];
    end

    assign angle_sel = cmd.axis ? angle_y_reg : angle_x_reg;
    assign acc_sel   = cmd.axis ? acc_y_reg : acc_x_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_GMUL:
            begin
                op_a = 33'(cmd.axis ? in_reg.gyro_x : in_reg.gyro_y);
                op_b = {1'b0, gyro_gain_reg};
            end
            OP_AMUL:
            begin
                op_a = 33'(a_cl);
                op_b = {1'b0, accel_gain_reg};
            end
            OP_BMUL_G:
            begin
                op_a = 33'(angle_sel);
                op_b = {17'b0, gyro_weight_reg};
            end
            OP_BMUL_A:
            begin
                op_a = 33'(acc_sel);
                op_b = {17'b0, accel_weight_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign gyro_sum  = cmd.axis ? 66'(angle_sel) + (prod_reg >>> 16)
                                : 66'(angle_sel) - (prod_reg >>> 16);
    assign blend_sum = (sum_reg + prod_reg) >>> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg    <= GYRO_GAIN_RST;
            accel_gain_reg   <= ACCEL_GAIN_RST;
            gyro_weight_reg  <= GYRO_WEIGHT_RST;
            accel_weight_reg <= ACCEL_WEIGHT_RST;
            mag_low_reg      <= MAG_LOW_RST;
            mag_high_reg     <= MAG_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GYRO_GAIN:    gyro_gain_reg    <= cfg_data[31:0];
                REG_ACCEL_GAIN:   accel_gain_reg   <= cfg_data[31:0];
                REG_GYRO_WEIGHT:  gyro_weight_reg  <= cfg_data[15:0];
                REG_ACCEL_WEIGHT: accel_weight_reg <= cfg_data[15:0];
                REG_MAG_LOW:      mag_low_reg      <= cfg_data[16:0];
                REG_MAG_HIGH:     mag_high_reg     <= cfg_data[16:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg   <= '0;
            angle_y_reg   <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_GADD:
                begin
                    if (cmd.axis)
                        angle_y_reg <= sat32(gyro_sum);
                    else
                        angle_x_reg <= sat32(gyro_sum);
                end
                OP_BFIN:
                begin
                    if (cmd.axis)
                        angle_y_reg <= sat32(blend_sum);
                    else
                        angle_x_reg <= sat32(blend_sum);
                end
                OP_CINIT:
                    iter_reg <= '0;
                OP_CSTEP:
                    iter_reg <= iter_reg + 1'b1;
                default:
                    ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                in_reg  <= in_data;
                use_reg <= use_next;
            end
            OP_GMUL, OP_AMUL, OP_BMUL_G:
                prod_reg <= op_a * op_b;
            OP_BMUL_A:
            begin
                sum_reg  <= prod_reg;
                prod_reg <= op_a * op_b;
            end
            OP_CINIT:
            begin
                zero_reg <= (side == 16'sd0) && (down == 16'sd0);
                if (down[15])
                begin
                    // down axis negative: pre-rotate by half a turn
                    cz_reg <= side[15] ? -PI_Q30 : PI_Q30;
                    cx_reg <= -x0;
                    cy_reg <= -y0;
                end
                else
                begin
                    cz_reg <= '0;
                    cx_reg <= x0;
                    cy_reg <= y0;
                end
            end
            OP_CSTEP:
            begin
                if (cy_reg > 34'sd0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_step;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_step;
                end
            end
            OP_ASAT:
            begin
                if (cmd.axis)
                    acc_y_reg <= zero_reg ? 32'sd0 : sat32(prod_reg >>> 16);
                else
                    acc_x_reg <= zero_reg ? 32'sd0 : sat32(prod_reg >>> 16);
            end
            OP_OUT:
            begin
                out_reg.tilt_x        <= angle_x_reg;
                out_reg.tilt_y        <= angle_y_reg;
                out_reg.accel_applied <= use_reg;
            end
            default:
                ;
        endcase
    end

    assign status.use_acc   = use_reg;
    assign status.iter_last = (iter_reg == IW'(CORDIC_STEPS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
